@@ rtl/tqh_pkg.sv @@
`default_nettype none
package tqh_pkg;
	localparam int AREA_W      = 35;
	localparam int OUT_W       = 32;
	localparam int LIMIT_W     = 12;
	localparam int NUM_LIMITS  = 4;
	localparam int NUM_CLASSES = 5;
	localparam int TOTAL_W     = 64;
	localparam int REG_IDX_W   = 2;

	localparam logic [AREA_W-1:0]  AREA_MAX      = {AREA_W{1'b1}};
	localparam logic [LIMIT_W-1:0] EXCELLENT_RST = LIMIT_W'(24);
	localparam logic [LIMIT_W-1:0] GOOD_RST      = LIMIT_W'(48);
	localparam logic [LIMIT_W-1:0] FAIR_RST      = LIMIT_W'(96);
	localparam logic [LIMIT_W-1:0] POOR_RST      = LIMIT_W'(160);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_EXCELLENT = 2'd0,
		REG_GOOD      = 2'd1,
		REG_FAIR      = 2'd2,
		REG_POOR      = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		CLS_EXCELLENT = 3'd0,
		CLS_GOOD      = 3'd1,
		CLS_FAIR      = 3'd2,
		CLS_POOR      = 3'd3,
		CLS_TERRIBLE  = 3'd4
	} class_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SQRT   = 6'b000010,
		ST_CLASS  = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_OUT    = 6'b100000
	} back_state_t;
endpackage
`default_nettype wire

@@ rtl/tqh_front.sv @@
`default_nettype none
module tqh_front #(
	parameter int COORD_BITS = 16,
	localparam int NW = 4*COORD_BITS + 6,
	localparam int LW = 2*COORD_BITS + 4,
	localparam int ENTRY_W = NW + LW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] cz,
	input  logic                         last_face,
	output logic                         q_push,
	output logic [ENTRY_W-1:0]           q_data,
	input  logic                         q_ready
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2*DW;
	localparam int H  = DW;

	function automatic logic signed [PW-1:0] mul_s(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [PW-1:0] ae;
		logic signed [PW-1:0] be;
		ae = a;
		be = b;
		return ae * be;
	endfunction

	function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] p,
			input logic signed [COORD_BITS-1:0] q);
		logic signed [DW-1:0] pe;
		logic signed [DW-1:0] qe;
		pe = p;
		qe = q;
		return pe - qe;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [DW-1:0] d_s1 [9];
	logic [PW-1:0] sq_s2 [9];
	logic signed [PW-1:0] p_s2 [6];
	logic [LW-1:0] lmax_s3, lmax_s4, lmax_s5;
	logic [PW-1:0] m_s3 [3];
	logic [2*H-1:0] hh_s4 [3];
	logic [2*H-1:0] hl_s4 [3];
	logic [2*H-1:0] ll_s4 [3];
	logic [NW-1:0] n_s5;
	logic [LW-1:0] l0, l1, l2, lmax_c;
	logic signed [PW:0] cr [3];
	logic [PW-1:0] mg [3];
	logic [NW-1:0] n_c;

	assign adv      = !v_s5 || q_ready;
	assign in_stall = !adv;
	assign q_push   = v_s5 && q_ready;
	assign q_data   = {n_s5, lmax_s5, last_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		l0 = LW'(sq_s2[0]) + LW'(sq_s2[1]) + LW'(sq_s2[2]);
		l1 = LW'(sq_s2[6]) + LW'(sq_s2[7]) + LW'(sq_s2[8]);
		l2 = LW'(sq_s2[3]) + LW'(sq_s2[4]) + LW'(sq_s2[5]);
		lmax_c = l0;
		if (l1 > lmax_c) lmax_c = l1;
		if (l2 > lmax_c) lmax_c = l2;
		for (int i = 0; i < 3; i++) begin
			cr[i] = (PW+1)'(p_s2[2*i]) - (PW+1)'(p_s2[2*i+1]);
			mg[i] = cr[i][PW] ? PW'(-cr[i]) : PW'(cr[i]);
		end
		n_c = '0;
		for (int i = 0; i < 3; i++) begin
			n_c = n_c + (NW'(hh_s4[i]) << (2*H)) + (NW'(hl_s4[i]) << (H+1))
				+ NW'(ll_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= diff(bx, ax);
			d_s1[1] <= diff(by_coord, ay);
			d_s1[2] <= diff(bz, az);
			d_s1[3] <= diff(cx, ax);
			d_s1[4] <= diff(cy, ay);
			d_s1[5] <= diff(cz, az);
			d_s1[6] <= diff(cx, bx);
			d_s1[7] <= diff(cy, by_coord);
			d_s1[8] <= diff(cz, bz);
			last_s1 <= last_face;

			for (int i = 0; i < 9; i++) sq_s2[i] <= mul_s(d_s1[i], d_s1[i]);
			p_s2[0] <= mul_s(d_s1[1], d_s1[5]);
			p_s2[1] <= mul_s(d_s1[2], d_s1[4]);
			p_s2[2] <= mul_s(d_s1[2], d_s1[3]);
			p_s2[3] <= mul_s(d_s1[0], d_s1[5]);
			p_s2[4] <= mul_s(d_s1[0], d_s1[4]);
			p_s2[5] <= mul_s(d_s1[1], d_s1[3]);
			last_s2 <= last_s1;

			lmax_s3 <= lmax_c;
			for (int i = 0; i < 3; i++) m_s3[i] <= mg[i];
			last_s3 <= last_s2;

			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= m_s3[i][2*H-1:H] * m_s3[i][2*H-1:H];
				hl_s4[i] <= m_s3[i][2*H-1:H] * m_s3[i][H-1:0];
				ll_s4[i] <= m_s3[i][H-1:0] * m_s3[i][H-1:0];
			end
			lmax_s4 <= lmax_s3;
			last_s4 <= last_s3;

			n_s5    <= n_c;
			lmax_s5 <= lmax_s4;
			last_s5 <= last_s4;
		end
	end
endmodule
`default_nettype wire

@@ rtl/tqh_queue.sv @@
`default_nettype none
module tqh_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign ready    = cnt_q != 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && ready) wr_q <= !wr_q;
			if (pop && valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && ready) - 2'(pop && valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push && ready) mem_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

@@ rtl/tqh_back.sv @@
`default_nettype none
module tqh_back #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 32,
	localparam int NW = 4*COORD_BITS + 6,
	localparam int LW = 2*COORD_BITS + 4,
	localparam int ENTRY_W = NW + LW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [ENTRY_W-1:0]            q_data,
	output logic                          q_pop,
	input  logic                          cfg_we,
	input  logic [tqh_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tqh_pkg::LIMIT_W-1:0]   cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tqh_pkg::OUT_W-1:0]     excellent_count,
	output logic [tqh_pkg::OUT_W-1:0]     good_count,
	output logic [tqh_pkg::OUT_W-1:0]     fair_count,
	output logic [tqh_pkg::OUT_W-1:0]     poor_count,
	output logic [tqh_pkg::OUT_W-1:0]     terrible_count,
	output logic [tqh_pkg::AREA_W-1:0]    min_area2,
	output logic [tqh_pkg::AREA_W-1:0]    max_area2,
	output logic [tqh_pkg::AREA_W-1:0]    avg_area2,
	output logic [tqh_pkg::OUT_W-1:0]     face_count
);
	import tqh_pkg::*;

	localparam int AW   = 2*COORD_BITS + 3;
	localparam int RW   = AW + 2;
	localparam int AXW  = (AW > AREA_W) ? AW : AREA_W;
	localparam int CMPW = LIMIT_W + AW;
	localparam int IW   = 7;
	localparam int CB   = COUNT_BITS;

	function automatic logic [OUT_W-1:0] clip32(input logic [CB-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
	endfunction

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == {CB{1'b1}}) ? v : v + CB'(1);
	endfunction

	back_state_t state_q;
	logic [LIMIT_W-1:0] lim_q [NUM_LIMITS];
	logic [NW-1:0] nsh_q;
	logic [RW-1:0] rem_q;
	logic [AW-1:0] root_q;
	logic [LW-1:0] lmax_q;
	logic          last_q;
	logic [IW-1:0] iter_q;
	class_t        cls_q;
	logic [CB-1:0] cnt_q [NUM_CLASSES];
	logic [AREA_W-1:0] least_q, great_q;
	logic [TOTAL_W-1:0] total_q, quo_q;
	logic [CB-1:0] faces_q, drem_q;
	logic out_valid_q;

	logic [RW-1:0] remx, trial;
	logic [CMPW-1:0] lhs, prod;
	logic degenerate;
	logic [AXW-1:0] a2e;
	logic [AREA_W-1:0] a2s;
	logic [TOTAL_W:0] tsum;
	logic [TOTAL_W-1:0] total_n;
	logic [CB:0] r2;
	logic out_load;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		remx  = {rem_q[RW-3:0], nsh_q[NW-1:NW-2]};
		trial = {root_q, 2'b01};
		lhs   = CMPW'({lmax_q, 4'b0000});
		prod  = CMPW'(lim_q[iter_q[1:0]]) * CMPW'(root_q);
		degenerate = (lmax_q == '0) || (root_q == '0);
		a2e   = AXW'(root_q);
		a2s   = (a2e > AXW'(AREA_MAX)) ? AREA_MAX : a2e[AREA_W-1:0];
		tsum  = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(a2s);
		total_n = tsum[TOTAL_W] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
		r2    = {drem_q, quo_q[TOTAL_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[0] <= EXCELLENT_RST;
			lim_q[1] <= GOOD_RST;
			lim_q[2] <= FAIR_RST;
			lim_q[3] <= POOR_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_EXCELLENT: lim_q[0] <= cfg_data;
				REG_GOOD:      lim_q[1] <= cfg_data;
				REG_FAIR:      lim_q[2] <= cfg_data;
				REG_POOR:      lim_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) cnt_q[i] <= '0;
			least_q <= AREA_MAX;
			great_q <= '0;
			total_q <= '0;
			faces_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (iter_q == '0) state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (degenerate || lhs < prod || iter_q[1:0] == 2'd3)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					for (int i = 0; i < NUM_CLASSES; i++) begin
						if (cls_q == class_t'(i)) cnt_q[i] <= sat_inc(cnt_q[i]);
					end
					if (a2s < least_q) least_q <= a2s;
					if (a2s > great_q) great_q <= a2s;
					total_q <= total_n;
					faces_q <= sat_inc(faces_q);
					state_q <= last_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (iter_q == '0) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < NUM_CLASSES; i++) cnt_q[i] <= '0;
						least_q <= AREA_MAX;
						great_q <= '0;
						total_q <= '0;
						faces_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				nsh_q  <= q_data[ENTRY_W-1 -: NW];
				lmax_q <= q_data[LW:1];
				last_q <= q_data[0];
				rem_q  <= '0;
				root_q <= '0;
				iter_q <= IW'(AW - 1);
			end
			ST_SQRT: begin
				nsh_q <= nsh_q << 2;
				if (remx >= trial) begin
					rem_q  <= remx - trial;
					root_q <= {root_q[AW-2:0], 1'b1};
				end else begin
					rem_q  <= remx;
					root_q <= {root_q[AW-2:0], 1'b0};
				end
				iter_q <= (iter_q == '0) ? '0 : iter_q - IW'(1);
			end
			ST_CLASS: begin
				priority if (degenerate) cls_q <= CLS_TERRIBLE;
				else if (lhs < prod) cls_q <= class_t'(iter_q[1:0]);
				else if (iter_q[1:0] == 2'd3) cls_q <= CLS_TERRIBLE;
				else iter_q <= iter_q + IW'(1);
			end
			ST_UPDATE: begin
				quo_q  <= total_n;
				drem_q <= '0;
				iter_q <= IW'(TOTAL_W - 1);
			end
			ST_DIV: begin
				if (r2 >= {1'b0, faces_q}) begin
					drem_q <= CB'(r2 - {1'b0, faces_q});
					quo_q  <= {quo_q[TOTAL_W-2:0], 1'b1};
				end else begin
					drem_q <= r2[CB-1:0];
					quo_q  <= {quo_q[TOTAL_W-2:0], 1'b0};
				end
				iter_q <= iter_q - IW'(1);
			end
			ST_OUT: begin
				if (out_load) begin
					excellent_count <= clip32(cnt_q[0]);
					good_count      <= clip32(cnt_q[1]);
					fair_count      <= clip32(cnt_q[2]);
					poor_count      <= clip32(cnt_q[3]);
					terrible_count  <= clip32(cnt_q[4]);
					min_area2       <= least_q;
					max_area2       <= great_q;
					avg_area2       <= (quo_q > TOTAL_W'(AREA_MAX)) ? AREA_MAX
						: quo_q[AREA_W-1:0];
					face_count      <= clip32(faces_q);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/triangle_quality_histogram.sv @@
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | ax..cz vertex coordinates, last_face
// out      | out_valid / out_stall| class counts, min/max/avg area2, face_count
// cfg      | cfg_we               | cfg_index, cfg_data (four 12-bit limits)
//
// front: 5-stage pipeline, one request per cycle unless stalled, into a 2-entry queue
// back: pops one entry in idle, then a bit-serial square root, class compares against
//   up to four limits, one update state; no new triangle is popped before that
// last triangle adds restoring division of area total by face count, then output
// reset clears statistics and restores limit defaults at once
// a stalled output does not stop the front until the queue fills
`default_nettype none
module triangle_quality_histogram #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  az,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by_coord,
	input  logic signed [COORD_BITS-1:0]  bz,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic signed [COORD_BITS-1:0]  cz,
	input  logic                          last_face,
	input  logic                          cfg_we,
	input  logic [tqh_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tqh_pkg::LIMIT_W-1:0]   cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tqh_pkg::OUT_W-1:0]     excellent_count,
	output logic [tqh_pkg::OUT_W-1:0]     good_count,
	output logic [tqh_pkg::OUT_W-1:0]     fair_count,
	output logic [tqh_pkg::OUT_W-1:0]     poor_count,
	output logic [tqh_pkg::OUT_W-1:0]     terrible_count,
	output logic [tqh_pkg::AREA_W-1:0]    min_area2,
	output logic [tqh_pkg::AREA_W-1:0]    max_area2,
	output logic [tqh_pkg::AREA_W-1:0]    avg_area2,
	output logic [tqh_pkg::OUT_W-1:0]     face_count
);
	import tqh_pkg::*;

	localparam int ENTRY_W = (4*COORD_BITS + 6) + (2*COORD_BITS + 4) + 1;

	logic               push, push_ready, q_valid, q_pop;
	logic [ENTRY_W-1:0] push_data, q_data;

	tqh_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.ax, .ay, .az, .bx, .by_coord, .bz, .cx, .cy, .cz, .last_face,
		.q_push(push), .q_data(push_data), .q_ready(push_ready)
	);

	tqh_queue #(.WIDTH(ENTRY_W)) u_queue (
		.clk, .arst_n,
		.push, .push_data, .ready(push_ready),
		.pop(q_pop), .valid(q_valid), .pop_data(q_data)
	);

	tqh_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop,
		.cfg_we, .cfg_index, .cfg_data,
		.out_valid, .out_stall,
		.excellent_count, .good_count, .fair_count, .poor_count, .terrible_count,
		.min_area2, .max_area2, .avg_area2, .face_count
	);
endmodule
`default_nettype wire

@@ rtl/tqh_checker.sv @@
`default_nettype none
module tqh_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tqh_pkg::OUT_W-1:0]  excellent_count,
	input logic [tqh_pkg::OUT_W-1:0]  good_count,
	input logic [tqh_pkg::OUT_W-1:0]  fair_count,
	input logic [tqh_pkg::OUT_W-1:0]  poor_count,
	input logic [tqh_pkg::OUT_W-1:0]  terrible_count,
	input logic [tqh_pkg::AREA_W-1:0] min_area2,
	input logic [tqh_pkg::AREA_W-1:0] max_area2,
	input logic [tqh_pkg::AREA_W-1:0] avg_area2,
	input logic [tqh_pkg::OUT_W-1:0]  face_count
);
	import tqh_pkg::*;

	logic [63:0] cls_sum;
	assign cls_sum = 64'(excellent_count) + 64'(good_count) + 64'(fair_count)
		+ 64'(poor_count) + 64'(terrible_count);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(face_count))
		else $error("output request dropped or changed under stall");

	a_faces_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face_count != '0)
		else $error("result with zero faces");

	a_class_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_count != {OUT_W{1'b1}} |-> cls_sum == 64'(face_count))
		else $error("class counts do not add up to face count");

	a_area_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_area2 <= avg_area2 && avg_area2 <= max_area2)
		else $error("average area outside min and max");
endmodule

bind triangle_quality_histogram tqh_checker u_tqh_checker (.*);
`default_nettype wire
